@@ hw/rtl/point_in_polygon_test_macros.svh @@
// assertion macros for the point in polygon block
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// concurrent check on clk_i, off during reset
`define PIP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pip check failed: lbl");

// signal holds while a transaction is stalled
`define PIP_ASSERT_HOLD(lbl, vld, rdy, sig) \
  `PIP_ASSERT(lbl, (vld && !rdy) |=> $stable(sig))

`endif

@@ hw/rtl/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// pip_pkg
// shared constants and types of the point in polygon block
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned COORD_BITS   = 16;
  localparam int unsigned MIN_VERTS    = 3;

  localparam int unsigned ADDR_W = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned A_W    = COORD_BITS + 2;
  localparam int unsigned P1_W   = 2 * COORD_BITS + 2;
  localparam int unsigned P2_W   = 2 * COORD_BITS + 3;
  localparam int unsigned CMP_W  = 2 * COORD_BITS + 5;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } pip_op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN,
    BK_OUT
  } pip_bk_state_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic [CNT_W-1:0]             n;
    logic                         ovf;
  } pip_query_t;

endpackage

@@ hw/rtl/pip_ram.sv @@
// ----------------------------------------------------------------------------
// pip_ram
// generic one write, one read port ram with registered read
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/pip_front.sv @@
// ----------------------------------------------------------------------------
// pip_front
// accepts transactions, keeps vertex count and overflow, queues queries
// ----------------------------------------------------------------------------
module pip_front import pip_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  input  logic                         full_i,
  input  logic                         empty_i,
  input  logic                         back_busy_i,
  output logic                         push_o,
  output pip_query_t                   query_o,
  output logic                         we_o,
  output logic [ADDR_W-1:0]            waddr_o,
  output logic [2*COORD_BITS-1:0]      wdata_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             acc;
  pip_op_e          op;

  assign op = pip_op_e'(op_i);

  // a clear waits until no query can still read the old vertices
  always_comb begin
    in_ready_o = 1'b1;
    case (op)
      OP_CLEAR: in_ready_o = empty_i && !back_busy_i;
      OP_QUERY: in_ready_o = !full_i;
      default:  in_ready_o = 1'b1;
    endcase
  end

  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    we_o    = 1'b0;
    push_o  = 1'b0;
    if (acc) begin
      case (op)
        OP_CLEAR: begin
          count_d = '0;
          ovf_d   = 1'b0;
        end
        OP_APPEND: begin
          if (count_q < CNT_W'(MAX_VERTICES)) begin
            we_o    = 1'b1;
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        OP_QUERY: push_o = 1'b1;
        default: ;
      endcase
    end
  end

  assign waddr_o     = count_q[ADDR_W-1:0];
  assign wdata_o     = {x_i, y_i};
  assign query_o.px  = x_i;
  assign query_o.py  = y_i;
  assign query_o.n   = count_q;
  assign query_o.ovf = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

@@ hw/rtl/pip_fifo.sv @@
// ----------------------------------------------------------------------------
// pip_fifo
// short query queue between front and back
// ----------------------------------------------------------------------------
module pip_fifo import pip_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pip_query_t data_i,
  input  logic       pop_i,
  output pip_query_t data_o,
  output logic       full_o,
  output logic       empty_o
);

  pip_query_t          buf_q [QDEPTH];
  logic [QPTR_W-1:0]   wptr_q, rptr_q;
  logic [QPTR_W:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == (QPTR_W+1)'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

endmodule

@@ hw/rtl/pip_back.sv @@
// ----------------------------------------------------------------------------
// pip_back
// walks polygon edges one per cycle through a three stage crossing pipeline
// ----------------------------------------------------------------------------
module pip_back import pip_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  pip_query_t                query_i,
  output logic                      pop_o,
  output logic                      busy_o,
  output logic                      re_o,
  output logic [ADDR_W-1:0]         raddr_o,
  input  logic [2*COORD_BITS-1:0]   rdata_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      inside_res_o,
  output logic                      too_few_o,
  output logic                      overflowed_o
);

  pip_bk_state_e state_q, state_d;
  logic [CNT_W-1:0] k_q, k_d, n_q;
  logic signed [COORD_BITS-1:0] px_q, py_q, prev_x_q, prev_y_q, xi, yi;
  logic inside_q, few_q, ovf_q;
  logic s0_v_q, s0_first_q;
  logic s1_v_q, s1_cross_q;
  logic signed [A_W-1:0]    s1_a_q;
  logic signed [DIFF_W-1:0] s1_dx_q, s1_dn_q, s1_den_q;
  logic s2_v_q, s2_cross_q, s2_neg_q;
  logic signed [P1_W-1:0]   s2_p1_q;
  logic signed [P2_W-1:0]   s2_p2_q;
  logic [DIFF_W-1:0]        s2_dd_q;
  logic signed [CMP_W-1:0]  n3, m3, dd3;
  logic left;
  logic start, start_few;

  assign xi = rdata_i[2*COORD_BITS-1:COORD_BITS];
  assign yi = rdata_i[COORD_BITS-1:0];

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    pop_o     = 1'b0;
    re_o      = 1'b0;
    raddr_o   = '0;
    start     = 1'b0;
    start_few = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          k_d   = '0;
          if (query_i.n < CNT_W'(MIN_VERTS)) begin
            start_few = 1'b1;
            state_d   = BK_OUT;
          end else begin
            start   = 1'b1;
            state_d = BK_RUN;
          end
        end
      end
      BK_RUN: begin
        re_o    = 1'b1;
        raddr_o = (k_q == '0) ? ADDR_W'(n_q - CNT_W'(1)) : ADDR_W'(k_q - CNT_W'(1));
        k_d     = k_q + CNT_W'(1);
        if (k_q == n_q) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (!s0_v_q && !s1_v_q && !s2_v_q) begin
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      k_q     <= '0;
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      s0_v_q  <= re_o;
      s1_v_q  <= s0_v_q && !s0_first_q;
      s2_v_q  <= s1_v_q;
    end
  end

  // final compare: a < trunc(num / d) with d > 0, done without division
  always_comb begin
    n3   = s2_neg_q ? -CMP_W'(s2_p1_q) : CMP_W'(s2_p1_q);
    m3   = s2_neg_q ? -CMP_W'(s2_p2_q) : CMP_W'(s2_p2_q);
    dd3  = $signed(CMP_W'(s2_dd_q));
    left = (n3 >= 0) ? (m3 + dd3 <= n3) : (m3 < n3);
  end

  always_ff @(posedge clk_i) begin
    if (start || start_few) begin
      px_q     <= query_i.px;
      py_q     <= query_i.py;
      n_q      <= query_i.n;
      ovf_q    <= query_i.ovf;
      few_q    <= start_few;
      inside_q <= 1'b0;
    end else if (s2_v_q && s2_cross_q && left) begin
      inside_q <= !inside_q;
    end
    s0_first_q <= (k_q == '0);
    if (s0_v_q) begin
      prev_x_q <= xi;
      prev_y_q <= yi;
    end
    s1_cross_q <= (yi > py_q) != (prev_y_q > py_q);
    s1_a_q     <= A_W'(px_q) - A_W'(xi);
    s1_dx_q    <= DIFF_W'(prev_x_q) - DIFF_W'(xi);
    s1_dn_q    <= DIFF_W'(py_q) - DIFF_W'(yi);
    s1_den_q   <= DIFF_W'(prev_y_q) - DIFF_W'(yi);
    s2_cross_q <= s1_cross_q;
    s2_p1_q    <= P1_W'(s1_dx_q) * P1_W'(s1_dn_q);
    s2_p2_q    <= P2_W'(s1_a_q) * P2_W'(s1_den_q);
    s2_neg_q   <= s1_den_q < 0;
    s2_dd_q    <= (s1_den_q < 0) ? DIFF_W'(-s1_den_q) : DIFF_W'(s1_den_q);
  end

  assign busy_o       = state_q != BK_IDLE;
  assign out_valid_o  = state_q == BK_OUT;
  assign inside_res_o = inside_q && !few_q;
  assign too_few_o    = few_q;
  assign overflowed_o = ovf_q;

endmodule

@@ hw/rtl/point_in_polygon_test.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_test
// even-odd point in polygon test over a stored integer polygon
// ----------------------------------------------------------------------------
// A query walks the polygon edges, reading one vertex a cycle from the
// vertex ram into a three stage multiply and compare pipeline; below three
// vertices the walk is skipped and the answer has too_few set. A two entry
// queue lets new vertices be appended while a query runs; a clear waits
// until all queued queries finish.
module point_in_polygon_test import pip_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         inside_res_o,
  output logic                         too_few_o,
  output logic                         overflowed_o
);

  logic                    push, full, empty, back_busy;
  pip_query_t              q_in, q_out;
  logic                    pop, we, re;
  logic [ADDR_W-1:0]       waddr, raddr;
  logic [2*COORD_BITS-1:0] wdata, rdata;

  pip_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .x_i, .y_i,
    .full_i(full), .empty_i(empty), .back_busy_i(back_busy),
    .push_o(push), .query_o(q_in),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata)
  );

  pip_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(q_in), .pop_i(pop),
    .data_o(q_out), .full_o(full), .empty_o(empty)
  );

  pip_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(MAX_VERTICES)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(re), .raddr_i(raddr), .rdata_o(rdata)
  );

  pip_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .query_i(q_out), .pop_o(pop),
    .busy_o(back_busy), .re_o(re), .raddr_o(raddr), .rdata_i(rdata),
    .out_valid_o, .out_ready_i, .inside_res_o, .too_few_o, .overflowed_o
  );

endmodule

@@ hw/rtl/pip_checker.sv @@
// ----------------------------------------------------------------------------
// pip_checker
// port level checks of the point in polygon block
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_macros.svh"

module pip_checker import pip_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [1:0]            op_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  inside_res_o,
  input logic                  too_few_o,
  input logic                  overflowed_o
);

  `PIP_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> out_valid_o)
  `PIP_ASSERT_HOLD(a_res_hold, out_valid_o, out_ready_i, inside_res_o)
  `PIP_ASSERT(a_few_outside, out_valid_o |-> !(inside_res_o && too_few_o))
  `PIP_ASSERT(a_clear_idle, (in_valid_i && in_ready_o && op_i == OP_CLEAR) |=> !out_valid_o)

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .out_valid_o, .out_ready_i,
  .inside_res_o, .too_few_o, .overflowed_o
);

@@ sim/point_in_polygon_test_tb.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_test_tb
// self-checking bench for the even-odd point in polygon block: directed
// table of clears, appends and queries, then random polygons and queries,
// every query answer checked against a behavioral polygon model
// ----------------------------------------------------------------------------
module point_in_polygon_test_tb import pip_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] x;
    logic [15:0] y;
    logic        chk;
    logic [2:0]  want;
  } stim_row_t;

  typedef struct {
    logic ins;
    logic few;
    logic ovf;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = OP_CLEAR;
  logic signed [COORD_BITS-1:0] x_i = '0;
  logic signed [COORD_BITS-1:0] y_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        inside_res_o;
  logic        too_few_o;
  logic        overflowed_o;

  point_in_polygon_test u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  longint  poly_x[MAX_VERTICES];
  longint  poly_y[MAX_VERTICES];
  int      poly_n = 0;
  bit      poly_ovf = 0;
  answer_t answer_q[$];
  int      err_count = 0;
  bit      calm = 0;
  bit      hold_off = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  function automatic bit crosses_left(longint px, longint py, int i, int j);
    longint xi, yi, dx, dn, den, q, a;
    xi = poly_x[i];
    yi = poly_y[i];
    dx = poly_x[j] - xi;
    dn = py - yi;
    den = poly_y[j] - yi;
    q = (dx * dn) / den;
    a = px - xi;
    return a < q;
  endfunction

  function automatic answer_t polygon_answer(longint px, longint py);
    answer_t r;
    int j;
    r.ins = 0;
    r.few = poly_n < MIN_VERTS;
    r.ovf = poly_ovf;
    if (!r.few) begin
      j = poly_n - 1;
      for (int i = 0; i < poly_n; i++) begin
        if ((poly_y[i] > py) != (poly_y[j] > py))
          if (crosses_left(px, py, i, j)) r.ins = !r.ins;
        j = i;
      end
    end
    return r;
  endfunction

  function automatic void apply_item(logic [1:0] op, logic signed [15:0] x,
                                     logic signed [15:0] y);
    case (op)
      OP_CLEAR: begin
        poly_n = 0;
        poly_ovf = 0;
      end
      OP_APPEND: begin
        if (poly_n < MAX_VERTICES) begin
          poly_x[poly_n] = x;
          poly_y[poly_n] = y;
          poly_n++;
        end else begin
          poly_ovf = 1;
        end
      end
      OP_QUERY: answer_q = {answer_q, polygon_answer(x, y)};
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [1:0] op, logic [15:0] x, logic [15:0] y);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    x_i <= x;
    y_i <= y;
    do @(posedge clk_i); while (!in_ready_o);
    apply_item(op, x, y);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i)
    out_ready_i <= !hold_off && (calm || $urandom_range(99) >= 18);

  always @(posedge clk_i) begin
    answer_t e;
    if (out_valid_o && out_ready_i) begin
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        e = answer_q.pop_front();
        if (inside_res_o !== e.ins) report_mismatch("inside_res", inside_res_o, e.ins);
        if (too_few_o !== e.few) report_mismatch("too_few", too_few_o, e.few);
        if (overflowed_o !== e.ovf) report_mismatch("overflowed", overflowed_o, e.ovf);
      end
    end
  end

  // rows: op, x, y, check, {inside, too_few, overflowed}
  stim_row_t directed[] = '{
    '{OP_QUERY,  16'h0000, 16'h0000, 1, 3'b010},
    '{OP_APPEND, 16'h8000, 16'h8000, 0, 0},
    '{OP_APPEND, 16'h7fff, 16'h8000, 0, 0},
    '{OP_QUERY,  16'h0000, 16'h0000, 1, 3'b010},
    '{OP_APPEND, 16'h7fff, 16'h7fff, 0, 0},
    '{OP_APPEND, 16'h8000, 16'h7fff, 0, 0},
    '{OP_QUERY,  16'h0000, 16'h0000, 1, 3'b100},
    '{OP_QUERY,  16'h8000, 16'h8000, 0, 0},
    '{OP_QUERY,  16'h7fff, 16'h7fff, 0, 0},
    '{OP_QUERY,  16'h7fff, 16'h0000, 0, 0},
    '{OP_QUERY,  16'h8000, 16'h0000, 0, 0},
    '{OP_NONE,   16'hffff, 16'hffff, 0, 0},
    '{OP_QUERY,  16'h5555, 16'haaaa, 0, 0},
    '{OP_CLEAR,  16'hffff, 16'hffff, 0, 0},
    '{OP_APPEND, 16'h0000, 16'h0000, 0, 0},
    '{OP_APPEND, 16'h0000, 16'h0000, 0, 0},
    '{OP_APPEND, 16'h0000, 16'h0000, 0, 0},
    '{OP_QUERY,  16'h0000, 16'h0000, 1, 3'b000},
    '{OP_CLEAR,  16'h0000, 16'h0000, 0, 0}
  };

  initial begin
    stim_row_t r;
    int nv;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[k]) begin
      r = directed[k];
      send_item(r.op, r.x, r.y);
      if (r.chk && {answer_q[$].ins, answer_q[$].few, answer_q[$].ovf} != r.want)
        report_mismatch("table row", k, -1);
    end
    // fill past capacity so the sticky overflow shows
    for (int k = 0; k < MAX_VERTICES + 2; k++)
      send_item(OP_APPEND, 16'($urandom), 16'($urandom));
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk_i);
        hold_off = 0;
      end
      repeat (5) send_item(OP_QUERY, 16'($urandom), 16'($urandom));
    join
    for (int n = 0; n < 1300; ) begin
      calm = (n >= 500 && n < 700);
      send_item(OP_CLEAR, 16'($urandom), 16'($urandom));
      nv = ($urandom_range(9) == 0) ? $urandom_range(MAX_VERTICES + 3)
                                    : $urandom_range(12);
      for (int v = 0; v < nv; v++) begin
        if ($urandom_range(19) == 0) send_item(OP_NONE, 16'($urandom), 16'($urandom));
        if ($urandom_range(1))
          send_item(OP_APPEND, 16'($urandom), 16'($urandom));
        else
          send_item(OP_APPEND, 16'($urandom_range(400) - 200),
                    16'($urandom_range(400) - 200));
      end
      for (int q = $urandom_range(8); q > 0; q--) begin
        if ($urandom_range(3) == 0)
          send_item(OP_QUERY, 16'($urandom), 16'($urandom));
        else
          send_item(OP_QUERY, 16'($urandom_range(500) - 250),
                    16'($urandom_range(500) - 250));
        n++;
      end
      n += nv + 1;
    end
    in_valid_i <= 1'b0;
    calm = 0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
